// ===== rtl/mhpq_pkg.sv =====
// Package for the min-heap priority queue: sizes, status codes and the
// structs passed between the top level and the queue cells. No dependencies.

package mhpq_pkg;

	localparam int HEAP_DEPTH = 64;
	localparam int KEY_WIDTH  = 32;
	localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
	localparam int OUT_CNT_W  = 7;
	localparam int OUT_KEY_W  = 32;

	typedef logic signed [KEY_WIDTH-1:0] key_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_POP  = 1'b1
	} op_t;

	// Command broadcast to every cell in the cycle of an accepted transaction.
	typedef struct packed {
		logic push;
		logic pop;
		key_t key;
	} cell_cmd_t;

	// What one cell shows its neighbors.
	typedef struct packed {
		logic valid;
		logic less;   // broadcast key sorts before this cell's key
		key_t key;
	} cell_view_t;

endpackage

// ===== rtl/mhpq_cell.sv =====
// One slot of the sorted queue chain. Holds a key and a valid bit and
// trades keys with its left and right neighbors. Depends on mhpq_pkg.

module mhpq_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  mhpq_pkg::cell_cmd_t cmd,
	input  mhpq_pkg::cell_view_t left,
	input  mhpq_pkg::cell_view_t right,
	output mhpq_pkg::cell_view_t view
);
	import mhpq_pkg::*;

	logic valid_q;
	key_t key_q;

	// An empty slot counts as +infinity.
	assign view.valid = valid_q;
	assign view.key   = key_q;
	assign view.less  = !valid_q || (cmd.key < key_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.push) begin
			if (left.less) begin
				valid_q <= left.valid;
			end else if (view.less) begin
				valid_q <= 1'b1;
			end
		end else if (cmd.pop) begin
			valid_q <= right.valid;
		end
	end

	// Shift in from the left where the new key lands further left,
	// drop the new key in here at the insertion point, shift left on pop.
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			if (left.less) begin
				key_q <= left.key;
			end else if (view.less) begin
				key_q <= cmd.key;
			end
		end else if (cmd.pop) begin
			key_q <= right.key;
		end
	end

endmodule

// ===== rtl/min_heap_priority_queue.sv =====
// Top level of the min-heap priority queue: a sorted chain of mhpq_cell
// slots with the occupancy count and the result register.
// Depends on mhpq_pkg and mhpq_cell.
//
// Raise start with opcode and key_value; the transaction is taken at the
// rising edge where start is high and busy is low. busy stays low: a new
// transaction may follow in every cycle. Opcode push inserts key_value,
// opcode pop removes the smallest key.
// Each transaction yields one result, shown for exactly one cycle with done
// high in the cycle right after acceptance (one transaction per
// cycle): status, the smallest key left (zero when empty), is_empty and
// entry_count after the operation. A push on a full queue is dropped with
// status FULL; a pop on an empty queue leaves it empty with status EMPTY.
// The keys sit in a row of HEAP_DEPTH cells kept in ascending order; a push
// compares the key against every cell at once and shifts the tail right by
// one cell, a pop shifts every cell left by one, so the smallest key is
// always in the first cell. The receiver cannot stall: results are taken in
// their single cycle. Reset clears every cell's valid bit and the count; the
// queue is empty and usable in the first cycle after reset.

module min_heap_priority_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        opcode,
	input  logic signed [31:0] key_value,
	output logic        done,
	output logic [1:0]  status,
	output logic signed [31:0] min_value,
	output logic        is_empty,
	output logic [6:0]  entry_count
);
	import mhpq_pkg::*;

	logic       accept;
	logic       is_pop;
	logic       full;
	logic       nonempty;
	cell_cmd_t  cmd;
	cell_view_t views [HEAP_DEPTH];
	cell_view_t none_view;
	cnt_t       count_q;
	status_t    status_q;
	logic       done_q;

	assign busy     = 1'b0;
	assign accept   = start && !busy;
	assign is_pop   = (op_t'(opcode) == OP_POP);
	assign full     = (count_q == cnt_t'(HEAP_DEPTH));
	assign nonempty = (count_q != '0);

	// Broadcast the operation; drop a push on full and a pop on empty.
	assign cmd.push = accept && !is_pop && !full;
	assign cmd.pop  = accept && is_pop && nonempty;
	assign cmd.key  = key_t'(key_value);

	// Edge neighbor: never shifts in, reads as an empty slot.
	assign none_view.valid = 1'b0;
	assign none_view.less  = 1'b0;
	assign none_view.key   = '0;

	for (genvar i = 0; i < HEAP_DEPTH; i++) begin : g_cell
		cell_view_t left_v;
		cell_view_t right_v;
		if (i == 0) begin : g_first
			assign left_v = none_view;
		end else begin : g_mid
			assign left_v = views[i-1];
		end
		if (i == HEAP_DEPTH - 1) begin : g_last
			assign right_v = none_view;
		end else begin : g_body
			assign right_v = views[i+1];
		end
		mhpq_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.cmd   (cmd),
			.left  (left_v),
			.right (right_v),
			.view  (views[i])
		);
	end

	// Hold the count and the result status; strobe done for one cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			status_q <= ST_OK;
			done_q   <= 1'b0;
		end else begin
			done_q <= accept;
			if (cmd.push) begin
				count_q <= count_q + cnt_t'(1);
			end else if (cmd.pop) begin
				count_q <= count_q - cnt_t'(1);
			end
			if (accept) begin
				if (!is_pop && full) begin
					status_q <= ST_FULL;
				end else if (is_pop && !nonempty) begin
					status_q <= ST_EMPTY;
				end else begin
					status_q <= ST_OK;
				end
			end
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign is_empty    = !views[0].valid;
	assign min_value   = views[0].valid ? OUT_KEY_W'(views[0].key) : '0;
	assign entry_count = OUT_CNT_W'(count_q);

endmodule

// ===== rtl/mhpq_checker.sv =====
// Port-level checks for min_heap_priority_queue, attached by bind.
// Depends on mhpq_pkg.

module mhpq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [1:0]  status,
	input logic signed [31:0] min_value,
	input logic        is_empty,
	input logic [6:0]  entry_count
);
	import mhpq_pkg::*;

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("result strobe missing after a transaction");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> !done)
		else $error("result strobe without a transaction");

	a_empty_view: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (is_empty == (entry_count == '0)) && (!is_empty || min_value == '0))
		else $error("empty flag, count and minimum disagree");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_FULL) |-> (entry_count == 7'(HEAP_DEPTH)))
		else $error("push dropped while queue not full");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_EMPTY) |-> is_empty)
		else $error("pop on empty reported with entries left");

endmodule

bind min_heap_priority_queue mhpq_checker u_mhpq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.status     (status),
	.min_value  (min_value),
	.is_empty   (is_empty),
	.entry_count(entry_count)
);
